[rtl/core/dbk_pkg.sv]
`timescale 1ns / 1ps
package dbk_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int XW         = ADDR_W + 1;
	localparam int BLOCK_SIZE = 8;
	localparam int BLK_BITS   = $clog2(BLOCK_SIZE);
	localparam int SEAM_REACH = 3;
	localparam int NUM_SLOTS  = 2 * SEAM_REACH;
	localparam int SLOT_W     = 3;
	localparam int CH_W       = 16;
	localparam int PIX_W      = 3 * CH_W;
	localparam int FULL_SCALE = 65280;
	localparam int MIX_MAX    = 256;
	localparam int ROUND_HALF = 768;
	localparam int DIV3_MUL   = 349526;
	localparam int DIV3_SHIFT = 20;
	localparam int SEAM_SPAN  = BLOCK_SIZE + SEAM_REACH - 1;
	localparam int ROW_PHASE  = SEAM_REACH - 1;
	localparam int CMDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 4;
	localparam int QA_W       = $clog2(CMDQ_DEPTH);
	localparam int QC_W       = QA_W + 1;

	localparam logic FN_PIXEL = 1'b0;
	localparam logic FN_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_SEAM_LIMIT   = 2'd2,
		REG_BLEND_AMOUNT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_RUN,
		BK_COL_RD,
		BK_COL_MEND,
		BK_COL_WR,
		BK_ROW,
		BK_DRAIN
	} bk_state_t;

	typedef logic [NUM_SLOTS-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic              wr;
		logic              emit;
		logic              last;
		logic              row_end;
		logic              row_pass;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] col;
		logic [XW-1:0]     width;
		logic [PIX_W-1:0]  data;
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic [ADDR_W-1:0] x;
		win_t              win;
	} mend_req_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       fend;
	} out_t;

	function automatic logic [SLOT_W-1:0] slot_wrap(input logic [3:0] v);
		logic [3:0] w;
		w = (v >= 4'(NUM_SLOTS)) ? v - 4'(NUM_SLOTS) : v;
		return w[SLOT_W-1:0];
	endfunction

	function automatic logic [7:0] to_byte(input logic [CH_W-1:0] v);
		logic [CH_W:0] s;
		s = {1'b0, v} + 17'd128;
		return (s[CH_W:8] > 9'd255) ? 8'd255 : s[15:8];
	endfunction

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [CH_W-1:0] step_level(input logic [CH_W-1:0] v,
		input logic [CH_W-1:0] s, input logic sub);
		logic signed [CH_W+1:0] r;
		r = sub ? $signed({2'b00, v}) - $signed({2'b00, s})
			: $signed({2'b00, v}) + $signed({2'b00, s});
		if (r < 0) return '0;
		if (r > 18'sd65280) return CH_W'(FULL_SCALE);
		return r[CH_W-1:0];
	endfunction

endpackage

[rtl/core/dbk_front.sv]
`timescale 1ns / 1ps
module dbk_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       q_full,
	input  logic                       func,
	input  logic [7:0]                 red_in,
	input  logic [7:0]                 green_in,
	input  logic [7:0]                 blue_in,
	input  logic [11:0]                image_width,
	input  logic [15:0]                image_height,
	output logic                       cmd_push,
	output dbk_pkg::cmd_t              cmd
);
	import dbk_pkg::*;

	logic [ADDR_W-1:0] col_q, e_col_q;
	logic [15:0]       row_q, e_row_q;
	logic [SLOT_W-1:0] slot_q, e_slot_q;
	logic [XW-1:0]     frame_w_q, w_eff, clamp_w;
	logic [15:0]       frame_h_q, h_eff, clamp_h;
	logic              full_q;
	logic              accept, first, is_pix, row_end, e_wrap, last, emit_pix;

	always_comb begin
		accept   = push && !q_full;
		is_pix   = (func == FN_PIXEL);
		first    = (col_q == '0) && (row_q == '0);
		clamp_w  = (image_width == '0) ? XW'(1)
			: ((image_width > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : image_width);
		clamp_h  = (image_height == '0) ? 16'd1 : image_height;
		w_eff    = first ? clamp_w : frame_w_q;
		h_eff    = first ? clamp_h : frame_h_q;
		row_end  = ({1'b0, col_q} + XW'(1)) >= w_eff;
		e_wrap   = ({1'b0, e_col_q} + XW'(1)) >= w_eff;
		last     = e_wrap && (e_row_q == h_eff - 16'd1);
		emit_pix = row_q >= 16'(NUM_SLOTS);
		cmd_push = accept && (is_pix ? !full_q : full_q);
		cmd.wr       = is_pix;
		cmd.emit     = is_pix ? emit_pix : 1'b1;
		cmd.last     = !is_pix && last;
		cmd.row_end  = is_pix && row_end;
		cmd.row_pass = is_pix && row_end && (row_q[BLK_BITS-1:0] == BLK_BITS'(ROW_PHASE))
			&& (row_q >= 16'(SEAM_SPAN));
		cmd.slot     = is_pix ? slot_q : e_slot_q;
		cmd.col      = is_pix ? col_q : e_col_q;
		cmd.width    = w_eff;
		cmd.data     = {red_in, 8'd0, green_in, 8'd0, blue_in, 8'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			slot_q    <= '0;
			e_col_q   <= '0;
			e_row_q   <= '0;
			e_slot_q  <= '0;
			frame_w_q <= XW'(1);
			frame_h_q <= 16'd1;
			full_q    <= 1'b0;
		end else if (accept) begin
			if (!is_pix && full_q) begin
				if (last) begin
					col_q    <= '0;
					row_q    <= '0;
					slot_q   <= '0;
					e_col_q  <= '0;
					e_row_q  <= '0;
					e_slot_q <= '0;
					full_q   <= 1'b0;
				end else if (e_wrap) begin
					e_col_q  <= '0;
					e_row_q  <= e_row_q + 16'd1;
					e_slot_q <= slot_wrap({1'b0, e_slot_q} + 4'd1);
				end else begin
					e_col_q <= e_col_q + 1'b1;
				end
			end
			if (is_pix && !full_q) begin
				if (first) begin
					frame_w_q <= clamp_w;
					frame_h_q <= clamp_h;
				end
				if (emit_pix) begin
					if (e_wrap) begin
						e_col_q  <= '0;
						e_row_q  <= e_row_q + 16'd1;
						e_slot_q <= slot_wrap({1'b0, e_slot_q} + 4'd1);
					end else begin
						e_col_q <= e_col_q + 1'b1;
					end
				end
				if (row_end) begin
					col_q  <= '0;
					row_q  <= row_q + 16'd1;
					slot_q <= slot_wrap({1'b0, slot_q} + 4'd1);
					if (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff})
						full_q <= 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/dbk_cmd_queue.sv]
`timescale 1ns / 1ps
module dbk_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  dbk_pkg::cmd_t wr_cmd,
	output logic          q_full,
	input  logic          rd_en,
	output logic          rd_valid,
	output dbk_pkg::cmd_t rd_cmd
);
	import dbk_pkg::*;

	cmd_t            mem_q [CMDQ_DEPTH];
	logic [QA_W-1:0] wp_q, rp_q;
	logic [QC_W-1:0] cnt_q;
	logic            do_wr, do_rd;

	always_comb begin
		q_full   = cnt_q == QC_W'(CMDQ_DEPTH);
		rd_valid = cnt_q != '0;
		rd_cmd   = mem_q[rp_q];
		do_wr    = wr_en && !q_full;
		do_rd    = rd_en && rd_valid;
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + QC_W'(do_wr) - QC_W'(do_rd);
		end
	end

endmodule

[rtl/core/dbk_mend.sv]
`timescale 1ns / 1ps
module dbk_mend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        limit,
	input  logic [8:0]         mix,
	input  dbk_pkg::mend_req_t req,
	output dbk_pkg::mend_req_t rsp
);
	import dbk_pkg::*;

	logic [24:0]     m_c [3];
	logic            ok_c [3];
	logic [CH_W-1:0] s_c [3][SEAM_REACH];
	win_t            win_d;

	logic              valid_s1, last_s1, valid_s2, last_s2, valid_s3, last_s3;
	logic [ADDR_W-1:0] x_s1, x_s2, x_s3;
	win_t              win_s1, win_s2, win_s3;
	logic              ok_s1 [3], neg_s1 [3], ok_s2 [3], neg_s2 [3];
	logic [24:0]       m_s1 [3];
	logic [CH_W-1:0]   s_s2 [3][SEAM_REACH];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ok_c[c] = (abs_diff(req.win[3][c*CH_W +: CH_W], req.win[2][c*CH_W +: CH_W])
					<= limit)
				&& (({1'b0, abs_diff(req.win[2][c*CH_W +: CH_W], req.win[1][c*CH_W +: CH_W])}
					+ {1'b0, abs_diff(req.win[1][c*CH_W +: CH_W],
					req.win[0][c*CH_W +: CH_W])}) <= {1'b0, limit})
				&& (({1'b0, abs_diff(req.win[3][c*CH_W +: CH_W], req.win[4][c*CH_W +: CH_W])}
					+ {1'b0, abs_diff(req.win[4][c*CH_W +: CH_W],
					req.win[5][c*CH_W +: CH_W])}) <= {1'b0, limit});
			m_c[c] = 25'(abs_diff(req.win[3][c*CH_W +: CH_W], req.win[2][c*CH_W +: CH_W]))
				* 25'(mix);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < SEAM_REACH; i++) begin
				s_c[c][i] = CH_W'((36'(17'((27'(m_s1[c]) * 27'(SEAM_REACH - i)
					+ 27'(ROUND_HALF)) >> 9)) * 36'(DIV3_MUL)) >> DIV3_SHIFT);
			end
		end
	end

	always_comb begin
		win_d = win_s2;
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < SEAM_REACH; i++) begin
				if (ok_s2[c]) begin
					win_d[SEAM_REACH-1-i][c*CH_W +: CH_W] =
						step_level(win_s2[SEAM_REACH-1-i][c*CH_W +: CH_W], s_s2[c][i],
						neg_s2[c]);
					win_d[SEAM_REACH+i][c*CH_W +: CH_W] =
						step_level(win_s2[SEAM_REACH+i][c*CH_W +: CH_W], s_s2[c][i],
						!neg_s2[c]);
				end
			end
		end
	end

	always_comb begin
		rsp.valid = valid_s3;
		rsp.last  = last_s3;
		rsp.x     = x_s3;
		rsp.win   = win_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= req.last;
		x_s1    <= req.x;
		win_s1  <= req.win;
		for (int c = 0; c < 3; c++) begin
			ok_s1[c]  <= ok_c[c];
			neg_s1[c] <= req.win[3][c*CH_W +: CH_W] < req.win[2][c*CH_W +: CH_W];
			m_s1[c]   <= m_c[c];
			ok_s2[c]  <= ok_s1[c];
			neg_s2[c] <= neg_s1[c];
			s_s2[c]   <= s_c[c];
		end
		last_s2 <= last_s1;
		x_s2    <= x_s1;
		win_s2  <= win_s1;
		last_s3 <= last_s2;
		x_s3    <= x_s2;
		win_s3  <= win_d;
	end

endmodule

[rtl/core/dbk_back.sv]
`timescale 1ns / 1ps
module dbk_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  dbk_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic [15:0]   limit,
	input  logic [8:0]    mix,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    red_out,
	output logic [7:0]    green_out,
	output logic [7:0]    blue_out,
	output logic          frame_end
);
	import dbk_pkg::*;

	bk_state_t state_q, state_d;

	logic [PIX_W-1:0]  bank_mem [NUM_SLOTS][MAX_WIDTH];
	logic [PIX_W-1:0]  rd_q [NUM_SLOTS];
	logic [ADDR_W-1:0] rd_addr;
	logic [NUM_SLOTS-1:0]   we;
	logic [ADDR_W-1:0] wr_addr [NUM_SLOTS];
	logic [PIX_W-1:0]  wr_data [NUM_SLOTS];

	logic [SLOT_W-1:0] slot_q, rdk_q, eslot_s1;
	logic [XW-1:0]     width_q, x_q;
	logic [2:0]        k_q;
	logic              row_pass_q, rdv_col_q, rdv_row_q, rlast_s1;
	logic [ADDR_W-1:0] rx_s1;
	logic              emit_s1, elast_s1;
	win_t              win_q, row_win;
	mend_req_t         mend_in, mend_out;
	logic              mend_on, room, issue_emit, has_col, next_seam, row_last;
	logic [ADDR_W-1:0] col_addr;

	out_t                oq_q [OUTQ_DEPTH];
	logic [QA_W-1:0]     owp_q, orp_q;
	logic [QC_W-1:0]     ocnt_q;
	logic                o_pop;
	out_t                o_new;

	dbk_mend u_mend (
		.clk    (clk),
		.arst_n (arst_n),
		.limit  (limit),
		.mix    (mix),
		.req    (mend_in),
		.rsp    (mend_out)
	);

	for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_bank
		always_ff @(posedge clk) begin
			if (we[j])
				bank_mem[j][wr_addr[j]] <= wr_data[j];
			rd_q[j] <= bank_mem[j][rd_addr];
		end
	end

	always_comb begin
		mend_on   = (limit != '0) && (mix != '0);
		room      = ({1'b0, ocnt_q} + (QC_W+1)'(emit_s1)) < (QC_W+1)'(OUTQ_DEPTH);
		has_col   = cmd.width > XW'(SEAM_SPAN);
		next_seam = (x_q + XW'(SEAM_SPAN)) < width_q;
		row_last  = x_q == width_q - XW'(1);
		col_addr  = ADDR_W'(x_q - XW'(SEAM_REACH) + XW'(k_q));
		for (int k = 0; k < NUM_SLOTS; k++)
			row_win[k] = rd_q[slot_wrap(4'(slot_q) + 4'd1 + 4'(k))];
		mend_in.valid = ((state_q == BK_COL_MEND) && (k_q == 3'd1)) || rdv_row_q;
		mend_in.last  = rlast_s1;
		mend_in.x     = rx_s1;
		mend_in.win   = (state_q == BK_COL_MEND) ? win_q : row_win;
	end

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		issue_emit = 1'b0;
		rd_addr    = x_q[ADDR_W-1:0];
		we         = '0;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			wr_addr[j] = mend_out.x;
			wr_data[j] = mend_out.win[slot_wrap(4'(j) + 4'(NUM_SLOTS - 1) - 4'(slot_q))];
		end
		case (state_q)
			BK_RUN: begin
				rd_addr = cmd.col;
				if (cmd_valid && (!cmd.emit || room)) begin
					cmd_pop    = 1'b1;
					issue_emit = cmd.emit;
					if (cmd.wr) begin
						we[cmd.slot]      = 1'b1;
						wr_addr[cmd.slot] = cmd.col;
						wr_data[cmd.slot] = cmd.data;
					end
					if (cmd.row_end && mend_on) begin
						if (has_col)
							state_d = BK_COL_RD;
						else if (cmd.row_pass)
							state_d = BK_ROW;
					end
				end
			end
			BK_COL_RD: begin
				rd_addr = col_addr;
				if (k_q == 3'(NUM_SLOTS - 1))
					state_d = BK_COL_MEND;
			end
			BK_COL_MEND: begin
				if (mend_out.valid)
					state_d = BK_COL_WR;
			end
			BK_COL_WR: begin
				we[slot_q]      = 1'b1;
				wr_addr[slot_q] = col_addr;
				wr_data[slot_q] = win_q[k_q];
				if (k_q == 3'(NUM_SLOTS - 1)) begin
					if (next_seam)
						state_d = BK_COL_RD;
					else if (row_pass_q)
						state_d = BK_ROW;
					else
						state_d = BK_RUN;
				end
			end
			BK_ROW: begin
				we = {NUM_SLOTS{mend_out.valid}};
				if (row_last)
					state_d = BK_DRAIN;
			end
			BK_DRAIN: begin
				we = {NUM_SLOTS{mend_out.valid}};
				if (mend_out.valid && mend_out.last)
					state_d = BK_RUN;
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_RUN;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			x_q        <= '0;
			slot_q     <= '0;
			width_q    <= XW'(1);
			row_pass_q <= 1'b0;
			rdv_col_q  <= 1'b0;
			rdv_row_q  <= 1'b0;
			emit_s1    <= 1'b0;
		end else begin
			rdv_col_q <= state_q == BK_COL_RD;
			rdv_row_q <= state_q == BK_ROW;
			emit_s1   <= issue_emit;
			case (state_q)
				BK_RUN: begin
					if (cmd_pop && cmd.row_end) begin
						slot_q     <= cmd.slot;
						width_q    <= cmd.width;
						row_pass_q <= cmd.row_pass;
						k_q        <= '0;
						x_q        <= has_col ? XW'(BLOCK_SIZE) : '0;
					end
				end
				BK_COL_RD: begin
					k_q <= (k_q == 3'(NUM_SLOTS - 1)) ? 3'd0 : k_q + 3'd1;
				end
				BK_COL_MEND: begin
					if (mend_out.valid)
						k_q <= '0;
					else if (k_q < 3'd2)
						k_q <= k_q + 3'd1;
				end
				BK_COL_WR: begin
					if (k_q == 3'(NUM_SLOTS - 1)) begin
						k_q <= '0;
						x_q <= next_seam ? x_q + XW'(BLOCK_SIZE) : '0;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				BK_ROW: begin
					x_q <= x_q + XW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rdk_q    <= k_q;
		rx_s1    <= x_q[ADDR_W-1:0];
		rlast_s1 <= row_last;
		eslot_s1 <= cmd.slot;
		elast_s1 <= cmd.last;
		if (rdv_col_q)
			win_q[rdk_q] <= rd_q[slot_q];
		if ((state_q == BK_COL_MEND) && mend_out.valid)
			win_q <= mend_out.win;
	end

	always_comb begin
		o_new.r    = to_byte(rd_q[eslot_s1][47:32]);
		o_new.g    = to_byte(rd_q[eslot_s1][31:16]);
		o_new.b    = to_byte(rd_q[eslot_s1][15:0]);
		o_new.fend = elast_s1;
		empty      = ocnt_q == '0;
		o_pop      = pop && !empty;
		red_out    = oq_q[orp_q].r;
		green_out  = oq_q[orp_q].g;
		blue_out   = oq_q[orp_q].b;
		frame_end  = oq_q[orp_q].fend;
	end

	always_ff @(posedge clk) begin
		if (emit_s1)
			oq_q[owp_q] <= o_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (emit_s1)
				owp_q <= owp_q + 1'b1;
			if (o_pop)
				orp_q <= orp_q + 1'b1;
			ocnt_q <= ocnt_q + QC_W'(emit_s1) - QC_W'(o_pop);
		end
	end

endmodule

[rtl/core/jpeg_block_seam_deblocker_core.sv]
`timescale 1ns / 1ps
// Smooths 8x8 block seams of an RGB raster stream, vertical seams first, then
// horizontal seams. Input is a queue port: push/full, with func selecting a
// pixel or a flush tick. Output is a queue port: empty/pop, oldest result on
// red_out/green_out/blue_out/frame_end while empty is low.
// A pixel transfer returns the pixel six rows above it; after the last row is
// in, each flush transfer returns the next held pixel, frame_end on the last.
// Pixels move at one per cycle while the back end runs and the output has room.
// A row end with mending on adds a pass per vertical seam (six store reads,
// the three-stage mend, six writes) and, on rows that close a horizontal
// seam, a pipelined pass over all six stored rows; the command queue keeps
// taking pixels meanwhile. Store reads are registered before the result queue.
// Write cfg_we/cfg_index/cfg_data only while idle. Reset clears counters and
// queues; the line store needs no clearing pass. A stalled pop fills the
// four-entry result queue, then the command queue, then full rises.
module jpeg_block_seam_deblocker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_end,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dbk_pkg::*;

	logic [11:0] image_width_q;
	logic [15:0] image_height_q, seam_limit_q, limit;
	logic [8:0]  blend_amount_q, mix;
	logic        cmd_push, cmd_pop, cmd_valid;
	cmd_t        f_cmd, b_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 12'd640;
			image_height_q <= 16'd480;
			seam_limit_q   <= '0;
			blend_amount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_SEAM_LIMIT:   seam_limit_q   <= cfg_data;
				REG_BLEND_AMOUNT: blend_amount_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		limit = (seam_limit_q > 16'(FULL_SCALE)) ? 16'(FULL_SCALE) : seam_limit_q;
		mix   = (blend_amount_q > 9'(MIX_MAX)) ? 9'(MIX_MAX) : blend_amount_q;
	end

	dbk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (full),
		.func         (func),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.cmd_push     (cmd_push),
		.cmd          (f_cmd)
	);

	dbk_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_cmd   (f_cmd),
		.q_full   (full),
		.rd_en    (cmd_pop),
		.rd_valid (cmd_valid),
		.rd_cmd   (b_cmd)
	);

	dbk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (b_cmd),
		.cmd_pop   (cmd_pop),
		.limit     (limit),
		.mix       (mix),
		.empty     (empty),
		.pop       (pop),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end)
	);

endmodule
